// File: rtl/assert_macros.svh
// assertion macros used by the top level of the tile binning block
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge while out of reset
`define TBIN_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define TBIN_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/tbin_pkg.sv
// shared types, widths and constants of the triangle tile binning block
// no dependencies
`default_nettype none

package tbin_pkg;

  localparam int unsigned CoordW    = 16;
  localparam int unsigned TileW     = 9;
  localparam int unsigned CfgW      = 10;
  localparam int unsigned IndexW    = 18;
  localparam int unsigned TileShift = 5;
  localparam int unsigned TileSize  = 1 << TileShift;
  localparam int unsigned NumEdges  = 3;

  // vertex minus tile corner, and vertex minus vertex
  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned ProdW = 2 * DiffW;
  // edge value plus corner offsets
  localparam int unsigned EdgeW = ProdW + 2;
  // bounding box bound in tile units, with sign
  localparam int unsigned BoxW  = CoordW - TileShift;

  typedef enum logic {
    CFG_TILES_ACROSS = 1'b0,
    CFG_TILES_DOWN   = 1'b1
  } cfg_reg_e;

  localparam logic [CfgW-1:0] TilesAcrossRst = CfgW'(40);
  localparam logic [CfgW-1:0] TilesDownRst   = CfgW'(23);

  typedef struct packed {
    logic signed [CoordW-1:0] first_x;
    logic signed [CoordW-1:0] first_y;
    logic signed [CoordW-1:0] second_x;
    logic signed [CoordW-1:0] second_y;
    logic signed [CoordW-1:0] third_x;
    logic signed [CoordW-1:0] third_y;
    logic [TileW-1:0]         tile_col;
    logic [TileW-1:0]         tile_row;
  } tri_tile_t;

  typedef struct packed {
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [ProdW-1:0] p;
    logic signed [ProdW-1:0] q;
  } edge_prod_t;

  typedef struct packed {
    edge_prod_t [NumEdges-1:0] edges;
    logic                      in_box;
    logic                      in_grid;
    logic [TileW-1:0]          tile_col;
    logic [IndexW-1:0]         row_base;
  } prod_t;

  typedef struct packed {
    logic              binned;
    logic              in_box;
    logic              in_grid;
    logic              touches;
    logic [IndexW-1:0] tile_index;
  } verdict_t;

endpackage

`default_nettype wire

// File: rtl/tbin_prod.sv
// first compute stage: edge products, bounding box, grid test, row base
// depends on tbin_pkg
`default_nettype none

module tbin_prod import tbin_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            ld_i,
  input  wire tri_tile_t       item_i,
  input  wire logic [CfgW-1:0] tiles_across_i,
  input  wire logic [CfgW-1:0] tiles_down_i,
  output      prod_t           prod_o
);

  // edges run second->first, third->second, first->third
  localparam int EdgeStart [NumEdges] = '{1, 2, 0};
  localparam int EdgeEnd   [NumEdges] = '{0, 1, 2};

  function automatic logic signed [CoordW-1:0] min3(
    input logic signed [CoordW-1:0] a,
    input logic signed [CoordW-1:0] b,
    input logic signed [CoordW-1:0] c
  );
    logic signed [CoordW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [CoordW-1:0] max3(
    input logic signed [CoordW-1:0] a,
    input logic signed [CoordW-1:0] b,
    input logic signed [CoordW-1:0] c
  );
    logic signed [CoordW-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // divide by the tile size, truncating toward zero
  function automatic logic signed [BoxW:0] tile_trunc(input logic signed [CoordW-1:0] v);
    logic signed [CoordW-1:0] adj;
    adj = v[CoordW-1] ? (v + CoordW'(TileSize - 1)) : v;
    return (BoxW+1)'(adj >>> TileShift);
  endfunction

  logic signed [CoordW-1:0] vx [NumEdges];
  logic signed [CoordW-1:0] vy [NumEdges];
  logic [TileW+TileShift-1:0] ax, ay;
  logic signed [DiffW-1:0] xa_off [NumEdges];
  logic signed [DiffW-1:0] ya_off [NumEdges];
  logic signed [BoxW:0] box_x0, box_x1, box_y0, box_y1;
  logic signed [BoxW:0] col_s, row_s;
  prod_t prod_d, prod_q;

  assign vx[0] = item_i.first_x;
  assign vy[0] = item_i.first_y;
  assign vx[1] = item_i.second_x;
  assign vy[1] = item_i.second_y;
  assign vx[2] = item_i.third_x;
  assign vy[2] = item_i.third_y;

  assign ax = {item_i.tile_col, {TileShift{1'b0}}};
  assign ay = {item_i.tile_row, {TileShift{1'b0}}};

  assign box_x0 = tile_trunc(min3(vx[0], vx[1], vx[2]));
  assign box_x1 = tile_trunc(max3(vx[0], vx[1], vx[2]));
  assign box_y0 = tile_trunc(min3(vy[0], vy[1], vy[2]));
  assign box_y1 = tile_trunc(max3(vy[0], vy[1], vy[2]));

  assign col_s = $signed((BoxW+1)'(item_i.tile_col));
  assign row_s = $signed((BoxW+1)'(item_i.tile_row));

  always_comb begin
    for (int e = 0; e < NumEdges; e++) begin
      xa_off[e] = DiffW'(vx[EdgeStart[e]]) - $signed(DiffW'(ax));
      ya_off[e] = DiffW'(vy[EdgeStart[e]]) - $signed(DiffW'(ay));
      prod_d.edges[e].dx = DiffW'(vx[EdgeEnd[e]]) - DiffW'(vx[EdgeStart[e]]);
      prod_d.edges[e].dy = DiffW'(vy[EdgeEnd[e]]) - DiffW'(vy[EdgeStart[e]]);
      // edge value at the tile's top-left corner is p - q
      prod_d.edges[e].p  = ProdW'(prod_d.edges[e].dx) * ProdW'(ya_off[e]);
      prod_d.edges[e].q  = ProdW'(xa_off[e]) * ProdW'(prod_d.edges[e].dy);
    end
    prod_d.in_box   = (col_s >= box_x0) && (col_s <= box_x1) &&
                      (row_s >= box_y0) && (row_s <= box_y1);
    prod_d.in_grid  = (CfgW'(item_i.tile_col) < tiles_across_i) &&
                      (CfgW'(item_i.tile_row) < tiles_down_i);
    prod_d.tile_col = item_i.tile_col;
    prod_d.row_base = IndexW'(item_i.tile_row) * IndexW'(tiles_across_i);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// File: rtl/tbin_verdict.sv
// second compute stage: corner signs per edge, verdicts and tile index
// depends on tbin_pkg
`default_nettype none

module tbin_verdict import tbin_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     ld_i,
  input  wire prod_t    prod_i,
  output      verdict_t verdict_o
);

  logic signed [EdgeW-1:0] e00 [NumEdges];
  logic signed [EdgeW-1:0] e10 [NumEdges];
  logic signed [EdgeW-1:0] e01 [NumEdges];
  logic signed [EdgeW-1:0] e11 [NumEdges];
  logic signed [EdgeW-1:0] step_x [NumEdges];
  logic signed [EdgeW-1:0] step_y [NumEdges];
  logic [NumEdges-1:0] all_nonneg;
  verdict_t verdict_d, verdict_q;

  always_comb begin
    for (int e = 0; e < NumEdges; e++) begin
      // moving one tile right adds T*dy, one tile down subtracts T*dx
      step_x[e] = EdgeW'(prod_i.edges[e].dy) <<< TileShift;
      step_y[e] = EdgeW'(prod_i.edges[e].dx) <<< TileShift;
      e00[e] = EdgeW'(prod_i.edges[e].p) - EdgeW'(prod_i.edges[e].q);
      e10[e] = e00[e] + step_x[e];
      e01[e] = e00[e] - step_y[e];
      e11[e] = e10[e] - step_y[e];
      all_nonneg[e] = !e00[e][EdgeW-1] && !e10[e][EdgeW-1] &&
                      !e01[e][EdgeW-1] && !e11[e][EdgeW-1];
    end
    verdict_d.touches    = ~|all_nonneg;
    verdict_d.in_box     = prod_i.in_box;
    verdict_d.in_grid    = prod_i.in_grid;
    verdict_d.binned     = prod_i.in_box && prod_i.in_grid && verdict_d.touches;
    verdict_d.tile_index = prod_i.row_base + IndexW'(prod_i.tile_col);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      verdict_q <= verdict_d;
    end
  end

  assign verdict_o = verdict_q;

endmodule

`default_nettype wire

// File: rtl/triangle_tile_binning_core.sv
// top level of the triangle tile binning block: handshakes, grid registers, pipeline
// depends on tbin_pkg, tbin_prod, tbin_verdict and assert_macros.svh
//
// One beat on the input channel carries a triangle (three integer pixel
// vertices) and a tile column and row; one beat on the output channel carries
// the verdicts (binned, in_box, in_grid, touches) and the row-major tile index.
// Tiles are 32 pixels square. The grid size sits in two registers written
// through the plain write port; the user is to write them only while no beat
// is in flight, which the block itself does not enforce. The pipeline has
// three registered stages: input register, edge product register, result
// register. With the output taken at once, one beat is accepted every cycle.
// The edge products are the longest path: one 17 by 17 multiply per product.
// When the receiver stalls, the result register holds its beat and the stages
// behind it keep filling; input ready drops only once all three stages hold a
// beat and the output is not taken.
// Reset empties all stages and loads the grid registers with 40 columns and
// 23 rows.
`default_nettype none

module triangle_tile_binning_core import tbin_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output      logic                     in_ready_o,
  input  wire logic signed [CoordW-1:0] first_x_i,
  input  wire logic signed [CoordW-1:0] first_y_i,
  input  wire logic signed [CoordW-1:0] second_x_i,
  input  wire logic signed [CoordW-1:0] second_y_i,
  input  wire logic signed [CoordW-1:0] third_x_i,
  input  wire logic signed [CoordW-1:0] third_y_i,
  input  wire logic [TileW-1:0]         tile_col_i,
  input  wire logic [TileW-1:0]         tile_row_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      logic                     binned_o,
  output      logic                     in_box_o,
  output      logic                     in_grid_o,
  output      logic                     touches_o,
  output      logic [IndexW-1:0]        tile_index_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [0:0]               cfg_index_i,
  input  wire logic [CfgW-1:0]          cfg_data_i
);

`include "assert_macros.svh"

  logic [CfgW-1:0] tiles_across_q, tiles_down_q;
  logic            s1_valid_q, s1_valid_d;
  logic            s2_valid_q, s2_valid_d;
  logic            s3_valid_q, s3_valid_d;
  logic            ld1, ld2, ld3;
  tri_tile_t       item_d, item_q;
  prod_t           prod;
  verdict_t        verdict;

  // grid size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tiles_across_q <= TilesAcrossRst;
      tiles_down_q   <= TilesDownRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_TILES_ACROSS: tiles_across_q <= cfg_data_i;
        CFG_TILES_DOWN:   tiles_down_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage advance: a stage loads when its source holds a beat and it is free or draining
  assign ld3 = s2_valid_q && (!s3_valid_q || out_ready_i);
  assign ld2 = s1_valid_q && (!s2_valid_q || ld3);
  assign in_ready_o = !s1_valid_q || ld2;
  assign ld1 = in_valid_i && in_ready_o;

  assign s1_valid_d = ld1 ? 1'b1 : (ld2 ? 1'b0 : s1_valid_q);
  assign s2_valid_d = ld2 ? 1'b1 : (ld3 ? 1'b0 : s2_valid_q);
  assign s3_valid_d = ld3 ? 1'b1 : (out_ready_i ? 1'b0 : s3_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      s3_valid_q <= s3_valid_d;
    end
  end

  always_comb begin
    item_d.first_x  = first_x_i;
    item_d.first_y  = first_y_i;
    item_d.second_x = second_x_i;
    item_d.second_y = second_y_i;
    item_d.third_x  = third_x_i;
    item_d.third_y  = third_y_i;
    item_d.tile_col = tile_col_i;
    item_d.tile_row = tile_row_i;
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      item_q <= item_d;
    end
  end

  tbin_prod u_prod (
    .clk_i          (clk_i),
    .ld_i           (ld2),
    .item_i         (item_q),
    .tiles_across_i (tiles_across_q),
    .tiles_down_i   (tiles_down_q),
    .prod_o         (prod)
  );

  tbin_verdict u_verdict (
    .clk_i     (clk_i),
    .ld_i      (ld3),
    .prod_i    (prod),
    .verdict_o (verdict)
  );

  assign out_valid_o  = s3_valid_q;
  assign binned_o     = verdict.binned;
  assign in_box_o     = verdict.in_box;
  assign in_grid_o    = verdict.in_grid;
  assign touches_o    = verdict.touches;
  assign tile_index_o = verdict.tile_index;

  // a beat entering an empty pipeline reaches the output via each stage register
  `TBIN_ASSERT(a_empty_latency, clk_i, rst_ni, (ld1 && !s1_valid_q && !s2_valid_q && !s3_valid_q) |-> ##3 out_valid_o, "beat lost in empty pipeline")
  // input stalls only with every stage full and the output held
  `TBIN_ASSERT(a_stall_full, clk_i, rst_ni, !in_ready_o |-> (s1_valid_q && s2_valid_q && s3_valid_q && !out_ready_i), "input stalled with room in pipeline")
  // a binned tile passed all three tests
  `TBIN_ASSERT(a_binned_tests, clk_i, rst_ni, (out_valid_o && binned_o) |-> (in_box_o && in_grid_o && touches_o), "binned without all tests passing")

endmodule

`default_nettype wire

// File: test/testbench.sv
// self-checking testbench for triangle_tile_binning_core: triangle and tile beats in, verdicts out
// depends on tbin_pkg and the rtl of the block; expected verdicts come from a scoreboard class

module testbench;
  import tbin_pkg::*;

  localparam longint TilePx = TileSize;

  class tile_bin_scoreboard;
    verdict_t verdicts_due[$];
    logic [CfgW-1:0] cols_cfg = TilesAcrossRst;
    logic [CfgW-1:0] rows_cfg = TilesDownRst;
    int unsigned mismatches = 0;

    function void set_grid(cfg_reg_e sel, logic [CfgW-1:0] val);
      if (sel == CFG_TILES_ACROSS) cols_cfg = val;
      else rows_cfg = val;
    endfunction

    // all four tile corners on the non-negative side of the edge p to q
    function bit corners_outside(longint px, longint py, longint qx, longint qy,
                                 longint lx, longint ly);
      longint cx, cy, e;
      for (int k = 0; k < 4; k++) begin
        cx = k[0] ? lx + TilePx : lx;
        cy = k[1] ? ly + TilePx : ly;
        e = (qx - px) * (py - cy) - (px - cx) * (qy - py);
        if (e < 0) return 0;
      end
      return 1;
    endfunction

    function verdict_t bin_verdict(tri_tile_t t);
      longint vx[3], vy[3];
      longint col, row, lo_x, hi_x, lo_y, hi_y;
      verdict_t v;
      vx[0] = $signed(t.first_x);
      vy[0] = $signed(t.first_y);
      vx[1] = $signed(t.second_x);
      vy[1] = $signed(t.second_y);
      vx[2] = $signed(t.third_x);
      vy[2] = $signed(t.third_y);
      col = t.tile_col;
      row = t.tile_row;
      lo_x = vx[0];
      hi_x = vx[0];
      lo_y = vy[0];
      hi_y = vy[0];
      for (int k = 1; k < 3; k++) begin
        if (vx[k] < lo_x) lo_x = vx[k];
        if (vx[k] > hi_x) hi_x = vx[k];
        if (vy[k] < lo_y) lo_y = vy[k];
        if (vy[k] > hi_y) hi_y = vy[k];
      end
      // signed division truncates toward zero, as the box bounds need
      v.in_box = col >= lo_x / TilePx && col <= hi_x / TilePx &&
                 row >= lo_y / TilePx && row <= hi_y / TilePx;
      v.in_grid = col < cols_cfg && row < rows_cfg;
      v.touches = 1'b1;
      // edges run second to first, third to second, first to third
      for (int k = 0; k < 3; k++)
        if (corners_outside(vx[(k + 1) % 3], vy[(k + 1) % 3], vx[k], vy[k],
                            col * TilePx, row * TilePx))
          v.touches = 1'b0;
      v.binned = v.in_box & v.in_grid & v.touches;
      v.tile_index = IndexW'(col + row * longint'(cols_cfg));
      return v;
    endfunction

    function void note_triangle(tri_tile_t t);
      verdicts_due.insert(verdicts_due.size(), bin_verdict(t));
    endfunction

    function void compare_field(string name, logic [IndexW-1:0] want,
                                logic [IndexW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        $display("%0t: verdict beat with none expected, tile_index %0h", $time,
                 got.tile_index);
        mismatches++;
        return;
      end
      want = verdicts_due.pop_front();
      compare_field("binned", IndexW'(want.binned), IndexW'(got.binned));
      compare_field("in_box", IndexW'(want.in_box), IndexW'(got.in_box));
      compare_field("in_grid", IndexW'(want.in_grid), IndexW'(got.in_grid));
      compare_field("touches", IndexW'(want.touches), IndexW'(got.touches));
      compare_field("tile_index", want.tile_index, got.tile_index);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tri_tile_t tri_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic binned, in_box, in_grid, touches;
  logic [IndexW-1:0] tile_index;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  tile_bin_scoreboard sb = new();

  triangle_tile_binning_core i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .first_x_i    (tri_in.first_x),
    .first_y_i    (tri_in.first_y),
    .second_x_i   (tri_in.second_x),
    .second_y_i   (tri_in.second_y),
    .third_x_i    (tri_in.third_x),
    .third_y_i    (tri_in.third_y),
    .tile_col_i   (tri_in.tile_col),
    .tile_row_i   (tri_in.tile_row),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .binned_o     (binned),
    .in_box_o     (in_box),
    .in_grid_o    (in_grid),
    .touches_o    (touches),
    .tile_index_o (tile_index),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_verdict(verdict_t'{binned, in_box, in_grid, touches, tile_index});
  end

  initial begin : receiver
    int unsigned held;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold so the pipeline fills and input ready drops
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (held = 0; held < 60; held++) @(negedge clk);
      end
      out_ready <= !(gaps_on && $urandom_range(99) < 17);
    end
  end

  initial begin : watchdog
    #2000000;
    $display("** triangle_tile_binning_core: FAILED **");
    $finish;
  end

  function automatic tri_tile_t make_item(int x0, int y0, int x1, int y1, int x2, int y2,
                                          int c, int r);
    tri_tile_t t;
    t.first_x = CoordW'(x0);
    t.first_y = CoordW'(y0);
    t.second_x = CoordW'(x1);
    t.second_y = CoordW'(y1);
    t.third_x = CoordW'(x2);
    t.third_y = CoordW'(y2);
    t.tile_col = TileW'(c);
    t.tile_row = TileW'(r);
    return t;
  endfunction

  function automatic tri_tile_t random_item(logic [CfgW-1:0] cols, logic [CfgW-1:0] rows);
    tri_tile_t t;
    longint vx[3], vy[3];
    longint cx, cy, span, dx, dy, m, n;
    int unsigned mode, col_top, row_top;
    mode = $urandom_range(99);
    if (mode < 25) begin
      // noise: any coordinates, any tile
      t.first_x = CoordW'($urandom);
      t.first_y = CoordW'($urandom);
      t.second_x = CoordW'($urandom);
      t.second_y = CoordW'($urandom);
      t.third_x = CoordW'($urandom);
      t.third_y = CoordW'($urandom);
      t.tile_col = TileW'($urandom);
      t.tile_row = TileW'($urandom);
      return t;
    end
    // tile inside or just past the grid, triangle around that tile
    col_top = (cols == 0) ? 4 : ((cols + 1 > 511) ? 511 : cols + 1);
    row_top = (rows == 0) ? 4 : ((rows + 1 > 511) ? 511 : rows + 1);
    t.tile_col = TileW'($urandom_range(col_top, 0));
    t.tile_row = TileW'($urandom_range(row_top, 0));
    cx = t.tile_col * TilePx + TilePx / 2;
    cy = t.tile_row * TilePx + TilePx / 2;
    span = (mode < 45) ? 24 : ((mode < 75) ? 80 : 200);
    for (int k = 0; k < 3; k++) begin
      vx[k] = cx + longint'($urandom_range(2 * span)) - span;
      vy[k] = cy + longint'($urandom_range(2 * span)) - span;
      // snap to tile corners so edges run through corners
      if ($urandom_range(3) == 0) begin
        vx[k] = (vx[k] / TilePx) * TilePx;
        vy[k] = (vy[k] / TilePx) * TilePx;
      end
    end
    if (mode >= 88) begin
      // collinear or single-point triangles
      dx = (mode >= 95) ? 0 : longint'($urandom_range(16)) - 8;
      dy = (mode >= 95) ? 0 : longint'($urandom_range(16)) - 8;
      m = longint'($urandom_range(12)) - 6;
      n = longint'($urandom_range(12)) - 6;
      vx[1] = vx[0] + m * dx;
      vy[1] = vy[0] + m * dy;
      vx[2] = vx[0] + n * dx;
      vy[2] = vy[0] + n * dy;
    end
    t.first_x = CoordW'(vx[0]);
    t.first_y = CoordW'(vy[0]);
    t.second_x = CoordW'(vx[1]);
    t.second_y = CoordW'(vy[1]);
    t.third_x = CoordW'(vx[2]);
    t.third_y = CoordW'(vy[2]);
    return t;
  endfunction

  // called and returns at a falling edge
  task automatic offer_item(tri_tile_t t);
    while (gaps_on && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    tri_in <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_triangle(t);
    @(negedge clk);
  endtask

  task automatic drain_verdicts();
    in_valid <= 1'b0;
    while (sb.verdicts_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_grid(logic [CfgW-1:0] cols, logic [CfgW-1:0] rows);
    drain_verdicts();
    cfg_we <= 1'b1;
    cfg_index <= CFG_TILES_ACROSS;
    cfg_data <= cols;
    sb.set_grid(CFG_TILES_ACROSS, cols);
    @(negedge clk);
    cfg_index <= CFG_TILES_DOWN;
    cfg_data <= rows;
    sb.set_grid(CFG_TILES_DOWN, rows);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CfgW-1:0] cols, rows;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed beats under the reset grid of 40 by 23
    offer_item(make_item(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0));
    offer_item(make_item(32767, 32767, 32767, 32767, 32767, 32767, 511, 511));
    offer_item(make_item(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
    offer_item(make_item(-32768, -32768, -32768, 32767, 32767, -32768, 0, 0));
    offer_item(make_item(-32768, -32768, 32767, -32768, -32768, 32767, 511, 0));
    offer_item(make_item(-32768, -32768, -32768, 32767, 32767, -32768, 0, 511));
    offer_item(make_item(32767, -32768, -32768, 32767, 0, 0, 511, 511));
    offer_item(make_item(5, 5, 20, 5, 5, 20, 0, 0));
    offer_item(make_item(5, 5, 5, 20, 20, 5, 0, 0));
    offer_item(make_item(5, 5, 20, 5, 5, 20, 1, 0));
    // negative box bounds truncate toward zero
    offer_item(make_item(-100, -100, -10, -50, -60, -5, 0, 0));
    offer_item(make_item(-100, -100, -5, -60, -50, -10, 0, 0));
    offer_item(make_item(0, 0, 64, 64, 128, 128, 1, 1));
    offer_item(make_item(1248, 704, 1279, 704, 1248, 735, 39, 22));
    offer_item(make_item(1280, 704, 1311, 704, 1280, 735, 40, 22));
    offer_item(make_item(1248, 736, 1279, 736, 1248, 767, 39, 23));
    offer_item(make_item(0, 0, 96, 0, 0, 96, 1, 1));
    offer_item(make_item(0, 0, 96, 0, 0, 96, 2, 1));

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin cols = 1; rows = 1; end
        1: begin cols = 512; rows = 512; end
        2: begin cols = 0; rows = 17; end
        3: begin cols = 9; rows = 0; end
        4: begin cols = 1023; rows = 1023; end
        5: begin cols = 1023; rows = 1; end
        6: begin
          cols = CfgW'($urandom_range(512, 1));
          rows = CfgW'($urandom_range(512, 1));
        end
        default: begin cols = TilesAcrossRst; rows = TilesDownRst; end
      endcase
      write_grid(cols, rows);
      gaps_on = (phase != 4);
      for (int i = 0; i < 205; i++) begin
        if (i == 100 && (phase == 1 || phase == 4 || phase == 7)) hold_req = 1'b1;
        offer_item(random_item(cols, rows));
      end
    end
    gaps_on = 1'b1;

    drain_verdicts();
    repeat (8) @(negedge clk);
    if (sb.mismatches == 0 && sb.verdicts_due.size() == 0)
      $display("** triangle_tile_binning_core: PASSED **");
    else
      $display("** triangle_tile_binning_core: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/tbin_pkg.sv
rtl/tbin_prod.sv
rtl/tbin_verdict.sv
rtl/triangle_tile_binning_core.sv
test/testbench.sv
